// ----- rtl/pae_pkg.sv -----
// Shared types and constants for the polynomial add and multiply engine.
package pae_pkg;

    localparam int MAX_DEG_DEF = 31;

    localparam int CMD_W      = 3;
    localparam int COEF_IN_W  = 16;
    localparam int EXP_IN_W   = 5;
    localparam int COEF_OUT_W = 40;
    localparam int EXP_OUT_W  = 6;
    localparam int SUM_W      = COEF_IN_W + 1;
    localparam int PROD_W     = 2 * COEF_IN_W;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUM    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PROD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_SCAN,
        ST_SUM_EMIT,
        ST_PROD_SETUP,
        ST_PROD_RUN,
        ST_PROD_DRAIN,
        ST_PROD_EMIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic                 wr_a;
        logic                 wr_b;
        logic                 clr_mask;
        logic                 rd_en;
        logic [EXP_IN_W-1:0]  rd_addr_a;
        logic [EXP_IN_W-1:0]  rd_addr_b;
        logic                 pair_v;
        logic                 acc_clr;
        logic                 cap_sum;
        logic                 cap_prod;
        logic [EXP_OUT_W-1:0] cap_exp;
        logic                 fin;
    } dp_cmd_t;

    typedef struct packed {
        logic pa;
        logic pb;
        logic pend_valid;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/pae_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pae_datapath.sv -----
// Datapath: coefficient stores, presence masks, multiply-accumulate, pending and output registers.
module pae_datapath #(
    parameter int MAX_DEG = pae_pkg::MAX_DEG_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pae_pkg::dp_cmd_t                       ctl,
    output pae_pkg::dp_stat_t                      stat,
    input  logic signed [pae_pkg::COEF_IN_W-1:0]   coef_in,
    input  logic [pae_pkg::EXP_IN_W-1:0]           exp_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pae_pkg::COEF_OUT_W-1:0]  coef_out,
    output logic [pae_pkg::EXP_OUT_W-1:0]          exp_out,
    output logic                                   empty_res,
    output logic                                   last
);

    localparam int DEPTH = MAX_DEG + 1;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW    = pae_pkg::COEF_IN_W;
    localparam int OW    = pae_pkg::COEF_OUT_W;
    localparam int EW    = pae_pkg::EXP_OUT_W;
    localparam int SW    = pae_pkg::SUM_W;
    localparam int PW    = pae_pkg::PROD_W;

    logic [DEPTH-1:0] a_mask_reg, a_mask_next;
    logic [DEPTH-1:0] b_mask_reg, b_mask_next;

    logic signed [CW-1:0] a_q, b_q;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr_a, raddr_b;

    logic                 rd_pa_reg, rd_pb_reg;
    logic                 rd_pair_reg;
    logic signed [PW-1:0] mul_reg;
    logic                 mul_v_reg;
    logic signed [OW-1:0] acc_reg, acc_next;
    logic                 hit_reg, hit_next;

    logic signed [CW-1:0] a_sel, b_sel;
    logic signed [SW-1:0] sum_w;
    logic signed [OW-1:0] sum_ext;
    logic signed [OW-1:0] cap_coef;
    logic                 cap;
    logic                 out_free;

    logic                 pend_valid_reg, pend_valid_next;
    logic signed [OW-1:0] pend_coef_reg, pend_coef_next;
    logic [EW-1:0]        pend_exp_reg, pend_exp_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [OW-1:0] out_coef_reg, out_coef_next;
    logic [EW-1:0]        out_exp_reg, out_exp_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_last_reg, out_last_next;

    assign waddr   = exp_in[AW-1:0];
    assign raddr_a = ctl.rd_addr_a[AW-1:0];
    assign raddr_b = ctl.rd_addr_b[AW-1:0];

    pae_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_a_ram (
        .clk   (clk),
        .we    (ctl.wr_a),
        .waddr (waddr),
        .wdata (coef_in),
        .re    (ctl.rd_en),
        .raddr (raddr_a),
        .rdata (a_q)
    );

    pae_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_b_ram (
        .clk   (clk),
        .we    (ctl.wr_b),
        .waddr (waddr),
        .wdata (coef_in),
        .re    (ctl.rd_en),
        .raddr (raddr_b),
        .rdata (b_q)
    );

    always_comb
    begin
        a_mask_next = a_mask_reg;
        b_mask_next = b_mask_reg;
        if (ctl.clr_mask)
        begin
            a_mask_next = '0;
            b_mask_next = '0;
        end
        if (ctl.wr_a)
        begin
            a_mask_next[waddr] = (coef_in != '0);
        end
        if (ctl.wr_b)
        begin
            b_mask_next[waddr] = (coef_in != '0);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign stat.pa         = a_mask_reg[raddr_a];
    assign stat.pb         = b_mask_reg[raddr_b];
    assign stat.pend_valid = pend_valid_reg;
    assign stat.hit        = hit_reg;
    assign stat.out_free   = out_free;

    assign a_sel   = rd_pa_reg ? a_q : '0;
    assign b_sel   = rd_pb_reg ? b_q : '0;
    assign sum_w   = {a_sel[CW-1], a_sel} + {b_sel[CW-1], b_sel};
    assign sum_ext = {{(OW-SW){sum_w[SW-1]}}, sum_w};

    always_comb
    begin
        acc_next = acc_reg;
        hit_next = hit_reg;
        if (ctl.acc_clr)
        begin
            acc_next = '0;
            hit_next = 1'b0;
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg + {{(OW-PW){mul_reg[PW-1]}}, mul_reg};
            hit_next = 1'b1;
        end
    end

    assign cap      = ctl.cap_sum || ctl.cap_prod;
    assign cap_coef = ctl.cap_sum ? sum_ext : acc_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_coef_next   = out_coef_reg;
        out_exp_next    = out_exp_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        if (cap)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_coef_next  = pend_coef_reg;
                out_exp_next   = pend_exp_reg;
                out_empty_next = 1'b0;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_coef_next  = cap_coef;
            pend_exp_next   = ctl.cap_exp;
        end
        else if (ctl.fin)
        begin
            out_valid_next  = 1'b1;
            out_coef_next   = pend_valid_reg ? pend_coef_reg : '0;
            out_exp_next    = pend_valid_reg ? pend_exp_reg : '0;
            out_empty_next  = !pend_valid_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_mask_reg     <= '0;
            b_mask_reg     <= '0;
            rd_pair_reg    <= 1'b0;
            mul_v_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            a_mask_reg     <= a_mask_next;
            b_mask_reg     <= b_mask_next;
            rd_pair_reg    <= ctl.rd_en && ctl.pair_v;
            mul_v_reg      <= rd_pair_reg;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_pa_reg <= stat.pa;
            rd_pb_reg <= stat.pb;
        end
        mul_reg       <= a_q * b_q;
        acc_reg       <= acc_next;
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign coef_out  = out_coef_reg;
    assign exp_out   = out_exp_reg;
    assign empty_res = out_empty_reg;
    assign last      = out_last_reg;

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctl.cap_sum || ctl.cap_prod) && pend_valid_reg) || ctl.fin |-> out_free)
        else $error("result pushed while output register still held");

    a_cap_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cap_prod |-> !rd_pair_reg && !mul_v_reg)
        else $error("product captured with pairs still in flight");

    a_clr_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc_clr |-> !rd_pair_reg && !mul_v_reg)
        else $error("accumulator cleared with pairs still in flight");

    a_fin_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin |=> !pend_valid_reg && out_valid_reg && out_last_reg)
        else $error("final request not delivered as last");

endmodule

// ----- rtl/pae_ctrl.sv -----
// Controller: command decode and exponent/pair sequencing for sum and product.
module pae_ctrl #(
    parameter int MAX_DEG = pae_pkg::MAX_DEG_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pae_pkg::CMD_W-1:0]     cmd,
    input  logic [pae_pkg::EXP_IN_W-1:0]  exp_in,
    output pae_pkg::dp_cmd_t              ctl,
    input  pae_pkg::dp_stat_t             stat
);

    localparam int DEPTH = MAX_DEG + 1;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int EW    = pae_pkg::EXP_OUT_W;
    localparam int IW    = pae_pkg::EXP_IN_W;
    localparam logic [EW-1:0] MAX_X   = EW'(MAX_DEG);
    localparam logic [EW-1:0] MAX_X2  = EW'(2 * MAX_DEG);

    pae_pkg::ctrl_state_t state_reg, state_next;
    logic [EW-1:0] x_reg, x_next;
    logic [AW-1:0] i_reg, i_next;
    logic          drain_reg, drain_next;

    logic [AW-1:0] i_lo, i_hi, j_idx;
    logic          accept;

    assign accept = in_valid && (state_reg == pae_pkg::ST_IDLE);
    assign i_lo   = (x_reg > MAX_X) ? AW'(x_reg - MAX_X) : '0;
    assign i_hi   = (x_reg < MAX_X) ? AW'(x_reg) : AW'(MAX_DEG);
    assign j_idx  = AW'(x_reg - EW'(i_reg));

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        i_next     = i_reg;
        drain_next = drain_reg;
        ctl        = '0;
        in_stall   = (state_reg != pae_pkg::ST_IDLE);
        case (state_reg)
            pae_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        pae_pkg::CMD_LOAD_A:
                            ctl.wr_a = (exp_in <= IW'(MAX_DEG));
                        pae_pkg::CMD_LOAD_B:
                            ctl.wr_b = (exp_in <= IW'(MAX_DEG));
                        pae_pkg::CMD_SUM:
                        begin
                            x_next     = MAX_X;
                            state_next = pae_pkg::ST_SUM_SCAN;
                        end
                        pae_pkg::CMD_PROD:
                        begin
                            x_next     = MAX_X2;
                            state_next = pae_pkg::ST_PROD_SETUP;
                        end
                        pae_pkg::CMD_CLEAR:
                            ctl.clr_mask = 1'b1;
                        default:
                            ;
                    endcase
                end
            end
            pae_pkg::ST_SUM_SCAN:
            begin
                ctl.rd_addr_a = IW'(x_reg);
                ctl.rd_addr_b = IW'(x_reg);
                if (stat.pa || stat.pb)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = pae_pkg::ST_SUM_EMIT;
                end
                else if (x_reg == '0)
                begin
                    state_next = pae_pkg::ST_FINISH;
                end
                else
                begin
                    x_next = x_reg - 1'b1;
                end
            end
            pae_pkg::ST_SUM_EMIT:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    ctl.cap_sum = 1'b1;
                    ctl.cap_exp = x_reg;
                    if (x_reg == '0)
                    begin
                        state_next = pae_pkg::ST_FINISH;
                    end
                    else
                    begin
                        x_next     = x_reg - 1'b1;
                        state_next = pae_pkg::ST_SUM_SCAN;
                    end
                end
            end
            pae_pkg::ST_PROD_SETUP:
            begin
                ctl.acc_clr = 1'b1;
                i_next      = i_lo;
                state_next  = pae_pkg::ST_PROD_RUN;
            end
            pae_pkg::ST_PROD_RUN:
            begin
                ctl.rd_en     = 1'b1;
                ctl.rd_addr_a = IW'(i_reg);
                ctl.rd_addr_b = IW'(j_idx);
                ctl.pair_v    = stat.pa && stat.pb;
                if (i_reg == i_hi)
                begin
                    drain_next = 1'b0;
                    state_next = pae_pkg::ST_PROD_DRAIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            pae_pkg::ST_PROD_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = pae_pkg::ST_PROD_EMIT;
                end
            end
            pae_pkg::ST_PROD_EMIT:
            begin
                if (!stat.hit || !stat.pend_valid || stat.out_free)
                begin
                    ctl.cap_prod = stat.hit;
                    ctl.cap_exp  = x_reg;
                    if (x_reg == '0)
                    begin
                        state_next = pae_pkg::ST_FINISH;
                    end
                    else
                    begin
                        x_next     = x_reg - 1'b1;
                        state_next = pae_pkg::ST_PROD_SETUP;
                    end
                end
            end
            pae_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.fin    = 1'b1;
                    state_next = pae_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pae_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pae_pkg::ST_IDLE;
            x_reg     <= '0;
            i_reg     <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            i_reg     <= i_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ----- rtl/polynomial_add_multiply_engine.sv -----
// Top level of the polynomial add and multiply engine.
// Loads and clear are taken in the idle state; no result request is produced.
// Sum: scans exponents from MAX_DEG down to 0, a scan and an emit step per present exponent.
// Product: for each result exponent from 2*MAX_DEG down to 0, one coefficient
// pair a cycle through the single shared multiplier; output stalls hold emit and finish.
// Reset (rst_n, asynchronous, active low) empties both presence masks and idles the controller.
module polynomial_add_multiply_engine #(
    parameter int MAX_DEG = pae_pkg::MAX_DEG_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pae_pkg::CMD_W-1:0]              cmd,
    input  logic signed [pae_pkg::COEF_IN_W-1:0]   coef_in,
    input  logic [pae_pkg::EXP_IN_W-1:0]           exp_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pae_pkg::COEF_OUT_W-1:0]  coef_out,
    output logic [pae_pkg::EXP_OUT_W-1:0]          exp_out,
    output logic                                   empty_res,
    output logic                                   last
);

    pae_pkg::dp_cmd_t  ctl;
    pae_pkg::dp_stat_t stat;

    pae_ctrl #(.MAX_DEG(MAX_DEG)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .exp_in   (exp_in),
        .ctl      (ctl),
        .stat     (stat)
    );

    pae_datapath #(.MAX_DEG(MAX_DEG)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .coef_in   (coef_in),
        .exp_in    (exp_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .coef_out  (coef_out),
        .exp_out   (exp_out),
        .empty_res (empty_res),
        .last      (last)
    );

endmodule
